@@ rtl/dqnp_pkg.sv @@
// Shared types and constants for the DNS query-name parser.
// No dependencies; imported by every module of the block.
package dqnp_pkg;

  // Default packet length limit in bytes
  localparam int unsigned MaxPacketBytesDef = 65535;

  // Configuration register defaults and indexes
  localparam logic [7:0] V4OffsetRst = 8'd28;
  localparam logic [7:0] V6OffsetRst = 8'd48;

  typedef enum logic {
    CFG_V4_OFFSET = 1'b0,
    CFG_V6_OFFSET = 1'b1
  } cfg_idx_e;

  // DNS header length and IP source-address windows
  localparam int unsigned DnsHdrLen  = 12;
  localparam int unsigned V4SrcFirst = 12;
  localparam int unsigned V4SrcEnd   = 16;
  localparam int unsigned V6SrcFirst = 8;
  localparam int unsigned V6SrcEnd   = 24;
  localparam logic [3:0]  IpVersion4 = 4'h4;
  localparam logic [7:0]  DotChar    = 8'h2e;

  // Result queue depth (two results may enter per cycle)
  localparam int unsigned OutDepth = 4;

  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_FINAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_NO_NAME   = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_e;

  // Parse phase, one-hot
  typedef enum logic [5:0] {
    PH_WAIT  = 6'b000001,
    PH_PRE   = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_LABEL = 6'b001000,
    PH_TYPE  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  // One result word
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] qkind;
    logic        v4;
    status_e     status;
    logic        last;
  } result_t;

  // Results produced by one accepted byte; push1 only with push0
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

@@ rtl/dqnp_parser.sv @@
// Byte-wide parse state and result generation for one accepted packet byte.
// Depends on dqnp_pkg.
module dqnp_parser #(
  parameter int unsigned MAX_PACKET_BYTES = dqnp_pkg::MaxPacketBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      pkt_byte_i,
  input  logic            end_of_packet_i,
  input  logic [7:0]      v4_offset_i,
  input  logic [7:0]      v6_offset_i,
  output dqnp_pkg::push_t push_o
);
  import dqnp_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CmpW = 17;

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      rem_q, rem_d;
  logic            v4_q, v4_d;
  logic            seen_q, seen_d;
  logic [15:0]     acc_q, acc_d;
  logic [1:0]      got_q, got_d;

  logic            parse;
  logic [7:0]      off;
  logic            addr;
  logic            is_len;
  logic            dvld;
  result_t         dres;
  result_t         fres;
  logic [7:0]      rem_dec;
  logic [1:0]      got_inc;

  // Work out next state and results of the byte on the input
  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    rem_d   = rem_q;
    v4_d    = v4_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    got_d   = got_q;
    is_len  = 1'b0;
    addr    = 1'b0;
    dvld    = 1'b0;
    rem_dec = rem_q - 8'd1;
    got_inc = got_q + 2'd1;
    dres    = '{kind: KIND_ADDR, data: pkt_byte_i, qkind: 16'd0, v4: 1'b0,
                status: ST_OK, last: 1'b0};
    parse   = pos_q < PosW'(MAX_PACKET_BYTES);

    if (parse) begin
      pos_d = pos_q + PosW'(1);
      if (phase_q == PH_WAIT) begin
        v4_d    = pkt_byte_i[7:4] == IpVersion4;
        phase_d = PH_PRE;
      end
    end
    off = v4_d ? v4_offset_i : v6_offset_i;

    if (parse) begin
      // Source-address window
      if (v4_d) begin
        addr = pos_q >= PosW'(V4SrcFirst) && pos_q < PosW'(V4SrcEnd);
      end else begin
        addr = pos_q >= PosW'(V6SrcFirst) && pos_q < PosW'(V6SrcEnd);
      end
      if (addr) begin
        dvld = 1'b1;
      end

      case (phase_d)
        PH_PRE: begin
          is_len = CmpW'(pos_q) == CmpW'(off) + CmpW'(DnsHdrLen);
        end
        PH_LEN: begin
          is_len = 1'b1;
        end
        PH_LABEL: begin
          if (!addr) begin
            dvld      = 1'b1;
            dres.kind = KIND_CHAR;
          end
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_d = PH_LEN;
          end
        end
        PH_TYPE: begin
          acc_d = {acc_q[7:0], pkt_byte_i};
          got_d = got_inc;
          if (got_inc >= 2'd2) begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase

      // Length byte: terminator or next label
      if (is_len) begin
        if (pkt_byte_i == 8'd0) begin
          phase_d = PH_TYPE;
        end else begin
          if (seen_q && !addr) begin
            dvld      = 1'b1;
            dres.kind = KIND_CHAR;
            dres.data = DotChar;
          end
          seen_d  = 1'b1;
          rem_d   = pkt_byte_i;
          phase_d = PH_LABEL;
        end
      end
    end
    dres.v4 = v4_d;

    // Final record, from the updated state
    fres = '{kind: KIND_FINAL, data: 8'd0, qkind: 16'd0, v4: v4_d,
             status: ST_TRUNCATED, last: 1'b1};
    case (phase_d)
      PH_DONE: begin
        fres.status = ST_OK;
        fres.qkind  = acc_d;
      end
      PH_PRE, PH_WAIT: begin
        fres.status = (CmpW'(pos_d) < CmpW'(off)) ? ST_SHORT : ST_NO_NAME;
      end
      default: ;
    endcase

    push_o.push0 = accept_i && (dvld || end_of_packet_i);
    push_o.push1 = accept_i && dvld && end_of_packet_i;
    push_o.res0  = dvld ? dres : fres;
    push_o.res1  = fres;

    // Drop packet state after the final byte
    if (end_of_packet_i) begin
      pos_d   = '0;
      phase_d = PH_WAIT;
      rem_d   = 8'd0;
      v4_d    = 1'b0;
      seen_d  = 1'b0;
      acc_d   = 16'd0;
      got_d   = 2'd0;
    end
  end

  // Hold parse state between accepted bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_WAIT;
      rem_q   <= 8'd0;
      v4_q    <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= 16'd0;
      got_q   <= 2'd0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      rem_q   <= rem_d;
      v4_q    <= v4_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      got_q   <= got_d;
    end
  end

  // A second result is always the final record behind a data word
  a_push1_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push1 |-> push_o.push0 && push_o.res1.last && !push_o.res0.last)
    else $error("second result without first data word");

  // End of packet returns the parser to its idle state
  a_eop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_packet_i |=> pos_q == '0 && phase_q == PH_WAIT)
    else $error("packet state not cleared after end of packet");

  // Type bytes are only collected until two have arrived
  a_got_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TYPE |-> got_q < 2'd2)
    else $error("query type byte count overrun");

endmodule

@@ rtl/dqnp_out_fifo.sv @@
// Result queue: takes up to two result words per cycle, gives one per cycle while popped.
// Depends on dqnp_pkg.
module dqnp_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqnp_pkg::push_t   push_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              pop_i,
  output dqnp_pkg::result_t head_o
);
  import dqnp_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  result_t         mem_q [OutDepth];
  logic [PtrW-1:0] wr_q, rd_q, wr_nxt;
  logic [CntW-1:0] cnt_q;
  logic            pop;
  logic [1:0]      n_push;

  assign pop     = pop_i && valid_o;
  assign n_push  = {1'b0, push_i.push0} + {1'b0, push_i.push1};
  assign wr_nxt  = wr_q + PtrW'(1);
  assign valid_o = cnt_q != '0;
  assign space_o = cnt_q <= CntW'(OutDepth - 2);
  assign head_o  = mem_q[rd_q];

  // Store result words
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_nxt] <= push_i.res1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(n_push);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OutDepth))
    else $error("result queue overflow");

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push0 |-> space_o)
    else $error("result pushed without room for two words");

  a_head_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !pop_i |=> valid_o && $stable(rd_q))
    else $error("queue head moved while stalled");

endmodule

@@ rtl/dns_query_name_parser.sv @@
// DNS query-name parser: accepts one packet byte per cycle while the queue has room
// for two words; result words are registered in a four-word queue before they leave.
// Throughput: one byte per cycle while each byte yields at most one result;
// the queue drains one word per cycle unless the output stalls.
// Reset clears the parse state and queue and loads payload offsets 28 / 48.
// Depends on dqnp_pkg, dqnp_parser and dqnp_out_fifo.
module dns_query_name_parser #(
  parameter int unsigned MAX_PACKET_BYTES = dqnp_pkg::MaxPacketBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // packet byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pkt_byte_i,
  input  logic        end_of_packet_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] query_kind_o,
  output logic        is_ipv4_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import dqnp_pkg::*;

  logic [7:0] v4_off_q, v6_off_q;
  logic       space;
  logic       accept;
  push_t      push;
  result_t    head;

  // Write payload offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_off_q <= V4OffsetRst;
      v6_off_q <= V6OffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_V4_OFFSET: v4_off_q <= cfg_data_i;
        CFG_V6_OFFSET: v6_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !space;
  assign accept     = in_valid_i && space;

  dqnp_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .pkt_byte_i     (pkt_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .v4_offset_i    (v4_off_q),
    .v6_offset_i    (v6_off_q),
    .push_o         (push)
  );

  dqnp_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .space_o(space),
    .valid_o(out_valid_o),
    .pop_i  (!out_stall_i),
    .head_o (head)
  );

  // Drive result word fields
  assign item_kind_o  = head.kind;
  assign data_byte_o  = head.data;
  assign query_kind_o = head.qkind;
  assign is_ipv4_o    = head.v4;
  assign status_o     = head.status;
  assign last_o       = head.last;

endmodule

@@ sim/dns_query_name_parser_tb.sv @@
// Self-checking testbench for dns_query_name_parser: directed and random packets,
// with a scoreboard that predicts every result word from a behavioral parser.
// Depends on dqnp_pkg and the RTL of dns_query_name_parser.
`timescale 1ns / 100ps

module dns_query_name_parser_tb;
  import dqnp_pkg::*;

  // Predicts the parser's result words and checks the words that leave the block
  class qname_scoreboard;
    result_t     expected_words[$];
    int unsigned errors;
    int unsigned max_bytes;

    // register copies
    logic [7:0]  v4_offset;
    logic [7:0]  v6_offset;

    // per-packet parse state
    int unsigned byte_pos;
    phase_e      phase;
    logic [7:0]  label_left;
    logic        ver_v4;
    logic        seen_label;
    logic [15:0] type_acc;
    int unsigned type_got;

    function new(int unsigned max_b);
      max_bytes = max_b;
      errors    = 0;
      v4_offset = V4OffsetRst;
      v6_offset = V6OffsetRst;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos   = 0;
      phase      = PH_WAIT;
      label_left = 8'd0;
      ver_v4     = 1'b0;
      seen_label = 1'b0;
      type_acc   = 16'd0;
      type_got   = 0;
    endfunction

    function void set_offset(cfg_idx_e idx, logic [7:0] val);
      if (idx == CFG_V4_OFFSET) begin
        v4_offset = val;
      end else begin
        v6_offset = val;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void add_expect(kind_e k, logic [7:0] d, logic [15:0] q, status_e s, logic l);
      result_t r;
      r.kind   = k;
      r.data   = d;
      r.qkind  = q;
      r.v4     = ver_v4;
      r.status = s;
      r.last   = l;
      expected_words.push_back(r);
    endfunction

    // Advance the parse by one accepted packet byte and queue its result words
    function void note_in_word(logic [7:0] b, logic eop);
      int unsigned idx;
      int unsigned off;
      logic        in_addr;
      logic        len_byte;
      status_e     st;
      logic [15:0] qk;
      if (byte_pos < max_bytes) begin
        idx      = byte_pos;
        byte_pos = byte_pos + 1;
        len_byte = 1'b0;
        if (phase == PH_WAIT) begin
          ver_v4 = (b[7:4] == IpVersion4);
          phase  = PH_PRE;
        end
        off     = ver_v4 ? v4_offset : v6_offset;
        in_addr = ver_v4 ? (idx >= V4SrcFirst && idx < V4SrcEnd)
                         : (idx >= V6SrcFirst && idx < V6SrcEnd);
        if (in_addr) add_expect(KIND_ADDR, b, 16'd0, ST_OK, 1'b0);

        case (phase)
          PH_PRE: begin
            if (idx >= off && idx - off == DnsHdrLen) len_byte = 1'b1;
          end
          PH_LEN: begin
            len_byte = 1'b1;
          end
          PH_LABEL: begin
            // a character inside the address window goes out only as an address byte
            if (!in_addr) add_expect(KIND_CHAR, b, 16'd0, ST_OK, 1'b0);
            label_left = label_left - 8'd1;
            if (label_left == 8'd0) phase = PH_LEN;
          end
          PH_TYPE: begin
            type_acc = {type_acc[7:0], b};
            type_got = type_got + 1;
            if (type_got >= 2) phase = PH_DONE;
          end
          default: ;
        endcase

        if (len_byte) begin
          if (b == 8'd0) begin
            phase = PH_TYPE;
          end else begin
            if (seen_label && !in_addr) add_expect(KIND_CHAR, DotChar, 16'd0, ST_OK, 1'b0);
            seen_label = 1'b1;
            label_left = b;
            phase      = PH_LABEL;
          end
        end
      end

      // close the packet with its final record
      if (eop) begin
        off = ver_v4 ? v4_offset : v6_offset;
        qk  = 16'd0;
        if (phase == PH_DONE) begin
          st = ST_OK;
          qk = type_acc;
        end else if (phase == PH_PRE || phase == PH_WAIT) begin
          st = (byte_pos < off) ? ST_SHORT : ST_NO_NAME;
        end else begin
          st = ST_TRUNCATED;
        end
        add_expect(KIND_FINAL, 8'd0, qk, st, 1'b1);
        clear_packet();
      end
    endfunction

    function void cmp_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compare one result word with the oldest expected word
    function void check_out_word(result_t got);
      result_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0h data %0h",
                 $time, got.kind, got.data);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      cmp_field("item_kind", exp_w.kind, got.kind);
      cmp_field("data_byte", exp_w.data, got.data);
      cmp_field("query_kind", exp_w.qkind, got.qkind);
      cmp_field("is_ipv4", exp_w.v4, got.v4);
      cmp_field("status", exp_w.status, got.status);
      cmp_field("last", exp_w.last, got.last);
    endfunction
  endclass

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseItems    = 310;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  cfg_idx_e    cfg_idx_i       = CFG_V4_OFFSET;
  logic [7:0]  cfg_data_i      = 8'd0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pkt_byte_i      = 8'd0;
  logic        end_of_packet_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  item_kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] query_kind_o;
  logic        is_ipv4_o;
  logic [1:0]  status_o;
  logic        last_o;

  int unsigned in_idle_pct  = 16;
  int unsigned out_idle_pct = 64;
  int unsigned quiet_cycles = 0;
  logic [7:0]  pkt_q[$];

  qname_scoreboard sb = new(MaxPacketBytesDef);

  dns_query_name_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pkt_byte_i     (pkt_byte_i),
    .end_of_packet_i(end_of_packet_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .item_kind_o    (item_kind_o),
    .data_byte_o    (data_byte_o),
    .query_kind_o   (query_kind_o),
    .is_ipv4_o      (is_ipv4_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  // Watch both handshakes: feed the scoreboard and count quiet cycles
  always @(posedge clk_i) begin : monitor_blk
    result_t got;
    logic    moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_in_word(pkt_byte_i, end_of_packet_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.kind   = kind_e'(item_kind_o);
        got.data   = data_byte_o;
        got.qkind  = query_kind_o;
        got.v4     = is_ipv4_o;
        got.status = status_e'(status_o);
        got.last   = last_o;
        sb.check_out_word(got);
        moved = 1'b1;
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one packet byte, idling first at random, and hold it until accepted
  task automatic send_word(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    pkt_byte_i      <= b;
    end_of_packet_i <= eop;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected word has left
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then give the pipeline time to finish bytes that produce nothing
  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register, then release the enable
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_offset(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_offset();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r < 4) return (r == 2) ? V4OffsetRst : V6OffsetRst;
    return 8'($urandom_range(40));
  endfunction

  task automatic rewrite_random_reg();
    settle();
    write_reg(cfg_idx_e'($urandom_range(1)), pick_offset());
  endtask

  // Build one packet in pkt_q: mostly well formed, some truncated, overrun or noise
  task automatic make_packet();
    int unsigned sel;
    int unsigned off;
    int unsigned nlab;
    int unsigned len;
    int unsigned cut;
    int          i;
    int          j;
    logic        v4;
    logic [7:0]  b0;
    pkt_q.delete();
    sel = $urandom_range(99);
    if (sel >= 88) begin
      len = $urandom_range(40, 1);
      for (i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
      return;
    end
    v4 = 1'($urandom_range(1));
    b0 = 8'($urandom);
    if (v4) begin
      b0[7:4] = IpVersion4;
    end else if (b0[7:4] == IpVersion4) begin
      b0[7:4] = 4'h6;
    end
    off = v4 ? sb.v4_offset : sb.v6_offset;
    pkt_q.push_back(b0);
    while (pkt_q.size() < off + DnsHdrLen) pkt_q.push_back(8'($urandom));
    if (sel >= 80) begin
      // label that runs past the end of the packet
      pkt_q.push_back(8'($urandom_range(255, 1)));
      len = $urandom_range(10);
      for (i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
      return;
    end
    nlab = $urandom_range(3);
    for (i = 0; i < nlab; i++) begin
      len = $urandom_range(8, 1);
      pkt_q.push_back(8'(len));
      for (j = 0; j < len; j++) pkt_q.push_back(8'($urandom));
    end
    pkt_q.push_back(8'd0);
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(8'($urandom));
    len = $urandom_range(3);
    for (i = 0; i < len; i++) pkt_q.push_back(8'($urandom));
    if (sel >= 70) begin
      cut = $urandom_range(pkt_q.size(), 1);
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end
  endtask

  // Send pkt_q as one packet; may pause midway to rewrite a register
  task automatic send_packet(input bit allow_split);
    int i;
    int split;
    split = -1;
    if (allow_split && pkt_q.size() > 1 && $urandom_range(99) < 8)
      split = $urandom_range(pkt_q.size() - 1, 1);
    for (i = 0; i < pkt_q.size(); i++) begin
      if (i == split) rewrite_random_reg();
      send_word(pkt_q[i], i == pkt_q.size() - 1);
    end
  endtask

  initial begin : stim_blk
    int          ph;
    int unsigned n_pkts;
    int unsigned phase_items;
    int          i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: IPv4 with payload at offset zero, so the name overlaps the address window
    write_reg(CFG_V4_OFFSET, 8'd0);
    pkt_q.delete();
    pkt_q.push_back(8'h4f);
    for (i = 1; i < DnsHdrLen; i++) pkt_q.push_back((i % 2) ? 8'hff : 8'h00);
    pkt_q.push_back(8'd3);
    pkt_q.push_back(8'h61);
    pkt_q.push_back(8'h62);
    pkt_q.push_back(8'h63);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'hff);
    pkt_q.push_back(8'hff);
    send_packet(1'b0);

    // Directed: one-byte IPv6 packet, shorter than its offset
    pkt_q.delete();
    pkt_q.push_back(8'h00);
    send_packet(1'b0);

    // Directed: end of packet on an address byte gives two words
    pkt_q.delete();
    pkt_q.push_back(8'h60);
    for (i = 1; i < V6SrcFirst; i++) pkt_q.push_back(8'($urandom));
    pkt_q.push_back(8'hff);
    send_packet(1'b0);

    // Random phases with different idle patterns and register settings
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_idle_pct  = 16;
          out_idle_pct = 64;
        end
        1: begin
          in_idle_pct  = 64;
          out_idle_pct = 16;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      settle();
      case (ph)
        0: begin
          write_reg(CFG_V4_OFFSET, 8'd255);
          write_reg(CFG_V6_OFFSET, 8'd0);
        end
        1: begin
          write_reg(CFG_V4_OFFSET, 8'd0);
          write_reg(CFG_V6_OFFSET, 8'd255);
        end
        default: begin
          write_reg(CFG_V4_OFFSET, V4OffsetRst);
          write_reg(CFG_V6_OFFSET, V6OffsetRst);
        end
      endcase
      n_pkts      = 0;
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        // hold off the sender until the result side has caught up
        if (n_pkts == 2) drain();
        if ($urandom_range(99) < 20) rewrite_random_reg();
        make_packet();
        // cut the last packet of the phase to the byte budget
        while (phase_items + pkt_q.size() > PhaseItems) void'(pkt_q.pop_back());
        send_packet(1'b1);
        phase_items += pkt_q.size();
        n_pkts++;
      end
    end

    // Wind down and report
    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected words never arrived", $time, sb.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dqnp_pkg.sv
rtl/dqnp_parser.sv
rtl/dqnp_out_fifo.sv
rtl/dns_query_name_parser.sv
sim/dns_query_name_parser_tb.sv
